>>> design/ipl_pkg.sv
// Package for the indexed point list: command and status codes, the result
// record passed from the sequencer to the output stage, and field widths.
// No dependencies.
package ipl_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned PT_W    = 2 * COORD_W;
  localparam int unsigned OCNT_W  = 7;

  typedef enum logic [3:0] {
    CMD_GET          = 4'd0,
    CMD_SET          = 4'd1,
    CMD_INSERT_AT    = 4'd2,
    CMD_INSERT_FIRST = 4'd3,
    CMD_INSERT_LAST  = 4'd4,
    CMD_DELETE_AT    = 4'd5,
    CMD_DELETE_FIRST = 4'd6,
    CMD_DELETE_LAST  = 4'd7,
    CMD_CLEAR        = 4'd8,
    CMD_COUNT        = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [OCNT_W-1:0]   entry_count;
    logic [COORD_W-1:0]  y_out;
    logic [COORD_W-1:0]  x_out;
  } res_t;

endpackage

>>> design/ipl_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ipl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ipl_seq.sv
// Command sequencer of the indexed point list: decodes one command, walks the
// point memory for shifts, keeps the entry count and builds the result.
// Depends on ipl_pkg.
module ipl_seq
  import ipl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          cmd,
  input  logic [IDX_W-1:0]    idx,
  input  logic [PT_W-1:0]     pt,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  output logic                ram_wr_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_wr_addr,
  output logic [PT_W-1:0]     ram_wr_data,
  output logic                ram_rd_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_rd_addr,
  input  logic [PT_W-1:0]     ram_rd_data
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_GETW, S_SHIFT, S_PUT, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_r, pend_nxt;
  logic [3:0]          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [PT_W-1:0]     pt_r, pt_nxt;
  logic                ins_r, ins_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       rptr_r, rptr_nxt;
  logic [CW-1:0]       wptr_r, wptr_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [PT_W-1:0]     rdat_r, rdat_nxt;
  status_t             st_r, st_nxt;

  logic          full;
  logic          in_range;
  logic [CW-1:0] idx_c;

  assign full     = (count_r == CW'(CAPACITY));
  assign in_range = (CMPW'(idx_r) < CMPW'(count_r));
  assign idx_c    = CW'(idx_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    pt_nxt      = pt_r;
    ins_nxt     = ins_r;
    pos_nxt     = pos_r;
    rptr_nxt    = rptr_r;
    wptr_nxt    = wptr_r;
    rem_nxt     = rem_r;
    rdat_nxt    = rdat_r;
    st_nxt      = st_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(pos_r);
    ram_wr_data = pt_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(idx_c);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd;
          idx_nxt   = idx;
          pt_nxt    = pt;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt    = ST_OK;
        rdat_nxt  = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_GET: begin
            if (in_range) begin
              ram_rd_en = 1'b1;
              state_nxt = S_GETW;
            end else begin
              st_nxt = ST_BAD_INDEX;
            end
          end
          CMD_SET: begin
            if (in_range) begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = AW'(idx_c);
            end else begin
              st_nxt = ST_BAD_INDEX;
            end
          end
          CMD_INSERT_AT, CMD_INSERT_FIRST: begin
            if (cmd_r == CMD_INSERT_FIRST && count_r == '0) begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = '0;
              count_nxt   = CW'(1);
            end else if (full) begin
              st_nxt = ST_FULL;
            end else if (cmd_r == CMD_INSERT_AT && !in_range) begin
              st_nxt = ST_BAD_INDEX;
            end else begin
              // Open a gap: move entries from the tail down to pos up by one.
              ins_nxt   = 1'b1;
              pos_nxt   = (cmd_r == CMD_INSERT_AT) ? idx_c : '0;
              rem_nxt   = count_r - pos_nxt;
              rptr_nxt  = count_r - CW'(1);
              state_nxt = S_SHIFT;
            end
          end
          CMD_INSERT_LAST: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = AW'(count_r);
              count_nxt   = count_r + CW'(1);
            end
          end
          CMD_DELETE_AT, CMD_DELETE_FIRST: begin
            if ((cmd_r == CMD_DELETE_AT) ? in_range : (count_r != '0)) begin
              // Close the gap: move entries after pos down by one.
              ins_nxt   = 1'b0;
              pos_nxt   = (cmd_r == CMD_DELETE_AT) ? idx_c : '0;
              rem_nxt   = count_r - pos_nxt - CW'(1);
              rptr_nxt  = pos_nxt + CW'(1);
              state_nxt = S_SHIFT;
            end else begin
              st_nxt = ST_BAD_INDEX;
            end
          end
          CMD_DELETE_LAST: begin
            if (count_r != '0) begin
              count_nxt = count_r - CW'(1);
            end else begin
              st_nxt = ST_EMPTY;
            end
          end
          CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_GETW: begin
        rdat_nxt  = ram_rd_data;
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        // Read one entry per cycle; the entry read last cycle is written
        // to its new place now. Read and write addresses never coincide.
        ram_wr_en   = pend_r;
        ram_wr_addr = AW'(wptr_r);
        ram_wr_data = ram_rd_data;
        if (rem_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(rptr_r);
          pend_nxt    = 1'b1;
          wptr_nxt    = ins_r ? rptr_r + CW'(1) : rptr_r - CW'(1);
          rptr_nxt    = ins_r ? rptr_r - CW'(1) : rptr_r + CW'(1);
          rem_nxt     = rem_r - CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (ins_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = AW'(pos_r);
          count_nxt   = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    pt_r   <= pt_nxt;
    ins_r  <= ins_nxt;
    pos_r  <= pos_nxt;
    rptr_r <= rptr_nxt;
    wptr_r <= wptr_nxt;
    rem_r  <= rem_nxt;
    rdat_r <= rdat_nxt;
    st_r   <= st_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.x_out       = rdat_r[COORD_W-1:0];
  assign res.y_out       = rdat_r[PT_W-1:COORD_W];
  assign res.entry_count = OCNT_W'(count_r);
  assign res.status      = st_r;

endmodule

>>> design/indexed_point_list.sv
// Top level of the indexed point list: stream ports, output register, and
// the sequencer and point memory instances. Depends on ipl_pkg, ipl_ram
// and ipl_seq.
//
//   channel | direction | payload (tdata, low bit first)           | bits
//   --------+-----------+-------------------------------------------+-----
//   in_     | to block  | cmd[3:0] index[9:4] x_bits y_bits         | 80
//   out_    | from block| x_out y_out entry_count[70:64] status     | 80
//
// Every command takes one transfer in and gives exactly one transfer out.
// On its way to the output register, a command for set, insert_last,
// delete_last, clear, count, insert_first on an empty list or any error
// passes through S_EXEC and S_DONE; get adds S_GETW (one registered memory
// read); insert_at, insert_first, delete_at and delete_first add S_SHIFT
// and S_PUT, since the point memory's single read and write ports move
// one entry per cycle.
// Reset (rst_n low, synchronous) empties the list; the point memory is not
// cleared, and positions beyond the count are never read.
// A stalled output holds its result; the next command is still taken and
// runs, then waits in the sequencer until the output register frees up.
module indexed_point_list
  import ipl_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // cmd, index, x_bits, y_bits, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // x_out, y_out, entry_count, status, zero pad
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Input field positions inside in_tdata.
  localparam int unsigned IN_IDX_LO = 4;
  localparam int unsigned IN_X_LO   = IN_IDX_LO + IDX_W;
  localparam int unsigned IN_Y_LO   = IN_X_LO + COORD_W;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [PT_W-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [PT_W-1:0] ram_rd_data;
  logic [PT_W-1:0] in_pt;

  logic out_tvalid_r, out_tvalid_nxt;
  res_t out_res_r, out_res_nxt;

  // Point memory word: x in the low half, y in the high half.
  assign in_pt = {in_tdata[IN_Y_LO +: COORD_W], in_tdata[IN_X_LO +: COORD_W]};

  ipl_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cmd         (in_tdata[3:0]),
    .idx         (in_tdata[IN_IDX_LO +: IDX_W]),
    .pt          (in_pt),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  ipl_ram #(
    .WIDTH (PT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The output register takes a finished result whenever it is empty or
  // its current result is transferred in the same cycle.
  assign res_ready = res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_res_nxt    = out_res_r;
    if (res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_res_nxt    = res;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r};

`ifndef SYNTH
  // The sequencer never takes a command while it still holds a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && res_valid))
    else $error("sequencer ready while holding a result");

  // A result blocked by a full, stalled output register stays pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_tvalid && !out_tready) |=> res_valid)
    else $error("pending result dropped while output stalled");

  // A reported count never exceeds the list capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_res_r.entry_count) <= CAPACITY || CAPACITY > 127))
    else $error("entry count above capacity");
`endif

endmodule
